FILE: hw/rtl/pid2_pkg.sv
`default_nettype none

package pid2_pkg;

    // Build-time controller constants, Q16.16
    localparam longint SAMPLE_PERIOD = 66;
    localparam longint FILTER_COEFF  = 6553600;

    // Filter pole factor 1 - N*Ts, both terms positive so the shift truncates toward zero
    localparam logic signed [33:0] ALPHA_Q = 34'(64'sd65536 - ((FILTER_COEFF * SAMPLE_PERIOD) >>> 16));
    localparam logic signed [33:0] N_Q     = 34'(FILTER_COEFF);
    localparam logic signed [47:0] TS_Q    = 48'(SAMPLE_PERIOD);

    localparam logic signed [49:0] SAT48_HI = 50'sh0_7FFF_FFFF_FFFF;
    localparam logic signed [49:0] SAT48_LO = 50'sh3_8000_0000_0000;
    localparam logic signed [47:0] SAT32_HI = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT32_LO = 48'shFFFF_8000_0000;

    typedef struct packed {
        logic signed [31:0] reference;
        logic signed [31:0] measurement;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] drive;
        logic               clamped;
    } t_out_item;

    typedef enum logic [2:0] {
        CFG_GAIN_PROP        = 3'd0,
        CFG_GAIN_INT         = 3'd1,
        CFG_GAIN_DERIV       = 3'd2,
        CFG_WEIGHT_PROP_REF  = 3'd3,
        CFG_WEIGHT_DERIV_REF = 3'd4,
        CFG_LIMIT_LOW        = 3'd5,
        CFG_LIMIT_HIGH       = 3'd6,
        CFG_MODE_BITS        = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [31:0] gain_prop;
        logic signed [31:0] gain_int;
        logic signed [31:0] gain_deriv;
        logic signed [31:0] weight_prop_ref;
        logic signed [31:0] weight_deriv_ref;
        logic signed [31:0] limit_low;
        logic signed [31:0] limit_high;
        logic [1:0]         mode_bits;
    } t_cfg;

    // Request to the shared multiplier: a is the narrow operand
    typedef struct packed {
        logic               start;
        logic signed [33:0] a;
        logic signed [47:0] b;
    } t_mul_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic signed [47:0] res;
    } t_mul_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_M_BR,
        ST_A_EP,
        ST_M_UP,
        ST_A_UP,
        ST_M_TS,
        ST_A_IN,
        ST_M_UI,
        ST_A_UI,
        ST_M_CR,
        ST_A_ED,
        ST_A_DF,
        ST_M_ND,
        ST_A_ND,
        ST_M_AF,
        ST_A_DN,
        ST_M_UD,
        ST_A_UR,
        ST_CLAMP
    } t_seq_state;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > SAT48_HI) begin
            r = SAT48_HI[47:0];
        end else if (v < SAT48_LO) begin
            r = SAT48_LO[47:0];
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT32_HI) begin
            r = SAT32_HI[31:0];
        end else if (v < SAT32_LO) begin
            r = SAT32_LO[31:0];
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pid_two_dof_controller.sv
`default_nettype none

// Two-degree-of-freedom PID with filtered derivative, signed Q16.16.
// Input channel: i_in_valid / o_in_stall carry one reference and measurement
// sample; a transaction completes when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry the drive value and the
// clamped flag from an output register; the result holds while stalled.
// Configuration: i_cfg_valid / o_cfg_ready with a register index and data;
// o_cfg_ready is always high. Write only while no sample is in progress.
// Eight Q16.16 products share one multiplier, each as two 34x24 partial
// products, a recombine and a saturate; nine add and store states and one
// limit state follow. The next sample is taken once the result has moved
// to the output register, so it may enter while the previous result still
// waits to be taken; a stalled output holds the final limit step until the
// register frees up.
// Reset clears the integrator, filter state and error history, sets gains
// and limits to zero, set-point weights to 1.0 and enables anti-windup only.
module pid_two_dof_controller
    import pid2_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg     w_cfg;
    t_mul_req w_mul_req;
    t_mul_rsp w_mul_rsp;

    pid2_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pid2_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    pid2_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg       (w_cfg),
        .o_mul_req   (w_mul_req),
        .i_mul_rsp   (w_mul_rsp)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/pid2_cfg.sv
`default_nettype none

module pid2_cfg
    import pid2_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_PROP:        n_cfg.gain_prop        = i_cfg_data;
                CFG_GAIN_INT:         n_cfg.gain_int         = i_cfg_data;
                CFG_GAIN_DERIV:       n_cfg.gain_deriv       = i_cfg_data;
                CFG_WEIGHT_PROP_REF:  n_cfg.weight_prop_ref  = i_cfg_data;
                CFG_WEIGHT_DERIV_REF: n_cfg.weight_deriv_ref = i_cfg_data;
                CFG_LIMIT_LOW:        n_cfg.limit_low        = i_cfg_data;
                CFG_LIMIT_HIGH:       n_cfg.limit_high       = i_cfg_data;
                CFG_MODE_BITS:        n_cfg.mode_bits        = i_cfg_data[1:0];
                default:              n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_prop        <= 32'sd0;
            r_cfg.gain_int         <= 32'sd0;
            r_cfg.gain_deriv       <= 32'sd0;
            r_cfg.weight_prop_ref  <= 32'sd65536;
            r_cfg.weight_deriv_ref <= 32'sd65536;
            r_cfg.limit_low        <= 32'sd0;
            r_cfg.limit_high       <= 32'sd0;
            r_cfg.mode_bits        <= 2'd2;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/pid2_mul.sv
`default_nettype none

// Shared Q16.16 multiplier: sign-magnitude, two 34x24 partial products, then
// recombine, shift by 16 toward zero and saturate to 48 bits.
module pid2_mul
    import pid2_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_mul_req  i_req,
    output t_mul_rsp  o_rsp
);

    logic [3:0]         r_ph;
    logic               r_done;
    logic [33:0]        r_ma;
    logic [47:0]        r_mb;
    logic               r_neg;
    logic [57:0]        r_pp_lo;
    logic [57:0]        r_pp_hi;
    logic [81:0]        r_mag;
    logic signed [47:0] r_res;

    logic [3:0]  n_ph;
    logic [33:0] w_ma;
    logic [47:0] w_mb;
    logic [23:0] w_mb_sel;
    logic [57:0] w_pp;
    logic [65:0] w_shift;
    logic [65:0] w_lim;
    logic [47:0] w_m;

    assign w_ma = i_req.a[33] ? 34'(-i_req.a) : i_req.a;
    assign w_mb = i_req.b[47] ? 48'(-i_req.b) : i_req.b;

    // one multiplier, low half of b first
    assign w_mb_sel = r_ph[0] ? r_mb[23:0] : r_mb[47:24];
    assign w_pp     = {24'd0, r_ma} * {34'd0, w_mb_sel};

    assign w_shift = r_mag[81:16];
    assign w_lim   = r_neg ? 66'h0_0000_8000_0000_0000 : 66'h0_0000_7FFF_FFFF_FFFF;
    assign w_m     = (w_shift > w_lim) ? w_lim[47:0] : w_shift[47:0];

    assign n_ph = {r_ph[2:0], i_req.start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 4'd0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= n_ph;
            r_done <= r_ph[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_ma  <= w_ma;
            r_mb  <= w_mb;
            r_neg <= i_req.a[33] ^ i_req.b[47];
        end
        if (r_ph[0]) begin
            r_pp_lo <= w_pp;
        end
        if (r_ph[1]) begin
            r_pp_hi <= w_pp;
        end
        if (r_ph[2]) begin
            r_mag <= {r_pp_hi, 24'd0} + {24'd0, r_pp_lo};
        end
        if (r_ph[3]) begin
            r_res <= r_neg ? -$signed(w_m) : $signed(w_m);
        end
    end

    assign o_rsp.busy = |r_ph;
    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

`ifndef SYNTH
    a_one_op_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({r_ph, r_done}))
        else $error("multiplier holds more than one transaction");

    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> ##5 o_rsp.done)
        else $error("multiplier result not ready after five cycles");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> !o_rsp.busy)
        else $error("multiplier done while still busy");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/pid2_seq.sv
`default_nettype none

module pid2_seq
    import pid2_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out_item o_out,
    input  t_cfg      i_cfg,
    output t_mul_req  o_mul_req,
    input  t_mul_rsp  i_mul_rsp
);

    t_seq_state r_state;
    t_seq_state n_state;

    logic signed [31:0] r_ref;
    logic signed [31:0] r_meas;
    logic signed [47:0] r_tmp;
    logic signed [49:0] r_acc;
    logic signed [47:0] r_inext;
    logic signed [47:0] r_ed;
    logic signed [47:0] r_dnext;
    logic signed [47:0] r_uraw;

    // controller state
    logic signed [47:0] r_integ;
    logic signed [32:0] r_pie;
    logic signed [47:0] r_fs;
    logic signed [47:0] r_pde;

    logic      r_out_valid;
    t_out_item r_out;

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_load;
    logic               w_mul_state;
    logic signed [49:0] w_add_a;
    logic signed [49:0] w_add_b;
    logic signed [49:0] w_sum;
    logic signed [47:0] w_sat;
    logic signed [49:0] w_prod;
    logic signed [49:0] w_meas;
    logic signed [47:0] w_lim_lo;
    logic signed [47:0] w_lim_hi;
    logic               w_above;
    logic               w_below;
    logic               w_clamped;
    logic               w_allow;
    logic signed [31:0] w_drive;

    assign w_in_acc  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_acc = r_out_valid && !i_out_stall;
    assign w_load    = (r_state == ST_CLAMP) && (!r_out_valid || !i_out_stall);

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_prod = {{2{i_mul_rsp.res[47]}}, i_mul_rsp.res};
    assign w_meas = {{18{r_meas[31]}}, r_meas};
    assign w_sum  = w_add_a + w_add_b;
    assign w_sat  = sat48(w_sum);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_in_acc) n_state = ST_M_BR;
            ST_M_BR:  if (i_mul_rsp.done) n_state = ST_A_EP;
            ST_A_EP:  n_state = ST_M_UP;
            ST_M_UP:  if (i_mul_rsp.done) n_state = ST_A_UP;
            ST_A_UP:  n_state = ST_M_TS;
            ST_M_TS:  if (i_mul_rsp.done) n_state = ST_A_IN;
            ST_A_IN:  n_state = ST_M_UI;
            ST_M_UI:  if (i_mul_rsp.done) n_state = ST_A_UI;
            ST_A_UI:  n_state = ST_M_CR;
            ST_M_CR:  if (i_mul_rsp.done) n_state = ST_A_ED;
            ST_A_ED:  n_state = ST_A_DF;
            ST_A_DF:  n_state = ST_M_ND;
            ST_M_ND:  if (i_mul_rsp.done) n_state = ST_A_ND;
            ST_A_ND:  n_state = ST_M_AF;
            ST_M_AF:  if (i_mul_rsp.done) n_state = ST_A_DN;
            ST_A_DN:  n_state = ST_M_UD;
            ST_M_UD:  if (i_mul_rsp.done) n_state = ST_A_UR;
            ST_A_UR:  n_state = ST_CLAMP;
            ST_CLAMP: if (w_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // operand selection for the multiplier and the saturating adder
    always_comb begin
        w_mul_state   = 1'b0;
        o_mul_req.a   = 34'sd0;
        o_mul_req.b   = 48'sd0;
        w_add_a       = 50'sd0;
        w_add_b       = 50'sd0;
        unique case (r_state)
            ST_M_BR: begin
                w_mul_state = 1'b1;
                o_mul_req.a = {{2{r_ref[31]}}, r_ref};
                o_mul_req.b = {{16{i_cfg.weight_prop_ref[31]}}, i_cfg.weight_prop_ref};
            end
            ST_A_EP: begin
                w_add_a = w_prod;
                w_add_b = -w_meas;
            end
            ST_M_UP: begin
                w_mul_state = 1'b1;
                o_mul_req.a = {{2{i_cfg.gain_prop[31]}}, i_cfg.gain_prop};
                o_mul_req.b = r_tmp;
            end
            ST_A_UP: begin
                w_add_a = w_prod;
            end
            ST_M_TS: begin
                w_mul_state = 1'b1;
                o_mul_req.a = {r_pie[32], r_pie};
                o_mul_req.b = TS_Q;
            end
            ST_A_IN: begin
                w_add_a = {{2{r_integ[47]}}, r_integ};
                w_add_b = w_prod;
            end
            ST_M_UI: begin
                w_mul_state = 1'b1;
                o_mul_req.a = {{2{i_cfg.gain_int[31]}}, i_cfg.gain_int};
                o_mul_req.b = r_inext;
            end
            ST_A_UI: begin
                w_add_a = r_acc;
                w_add_b = w_prod;
            end
            ST_M_CR: begin
                w_mul_state = 1'b1;
                o_mul_req.a = {{2{r_ref[31]}}, r_ref};
                o_mul_req.b = {{16{i_cfg.weight_deriv_ref[31]}}, i_cfg.weight_deriv_ref};
            end
            ST_A_ED: begin
                w_add_a = w_prod;
                w_add_b = -w_meas;
            end
            ST_A_DF: begin
                w_add_a = {{2{r_ed[47]}}, r_ed};
                w_add_b = -{{2{r_pde[47]}}, r_pde};
            end
            ST_M_ND: begin
                w_mul_state = 1'b1;
                o_mul_req.a = N_Q;
                o_mul_req.b = r_tmp;
            end
            ST_M_AF: begin
                w_mul_state = 1'b1;
                o_mul_req.a = ALPHA_Q;
                o_mul_req.b = r_fs;
            end
            ST_A_DN: begin
                w_add_a = w_prod;
                w_add_b = {{2{r_tmp[47]}}, r_tmp};
            end
            ST_M_UD: begin
                w_mul_state = 1'b1;
                o_mul_req.a = {{2{i_cfg.gain_deriv[31]}}, i_cfg.gain_deriv};
                o_mul_req.b = r_dnext;
            end
            ST_A_UR: begin
                w_add_a = r_acc;
                w_add_b = w_prod;
            end
            default: begin
                w_mul_state = 1'b0;
            end
        endcase
        // issue once on entry, then wait for the result
        o_mul_req.start = w_mul_state && !i_mul_rsp.busy && !i_mul_rsp.done;
    end

    // output limits and anti-windup decision
    always_comb begin
        w_lim_lo  = {{16{i_cfg.limit_low[31]}}, i_cfg.limit_low};
        w_lim_hi  = {{16{i_cfg.limit_high[31]}}, i_cfg.limit_high};
        w_above   = r_uraw > w_lim_hi;
        w_below   = r_uraw < w_lim_lo;
        w_clamped = 1'b0;
        if (i_cfg.mode_bits[0]) begin
            // upper limit wins when the limits are crossed
            if (w_above) begin
                w_drive   = i_cfg.limit_high;
                w_clamped = 1'b1;
            end else if (w_below) begin
                w_drive   = i_cfg.limit_low;
                w_clamped = 1'b1;
            end else begin
                w_drive = r_uraw[31:0];
            end
        end else begin
            w_drive = sat32(r_uraw);
        end
        w_allow = !(i_cfg.mode_bits[1] && w_clamped &&
                    ((w_above && (r_pie > 33'sd0)) || (w_below && (r_pie < 33'sd0))));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_integ     <= 48'sd0;
            r_pie       <= 33'sd0;
            r_fs        <= 48'sd0;
            r_pde       <= 48'sd0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (w_load) begin
                // freeze the integrator while pushing into the limit
                if (w_allow) begin
                    r_integ <= r_inext;
                end
                r_fs  <= r_dnext;
                r_pde <= r_ed;
                r_pie <= {r_ref[31], r_ref} - {r_meas[31], r_meas};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ref  <= i_in.reference;
            r_meas <= i_in.measurement;
        end
        unique case (r_state)
            ST_A_EP: r_tmp   <= w_sat;
            ST_A_UP: r_acc   <= w_sum;
            ST_A_IN: r_inext <= w_sat;
            ST_A_UI: r_acc   <= w_sum;
            ST_A_ED: r_ed    <= w_sat;
            ST_A_DF: r_tmp   <= w_sat;
            ST_A_ND: r_tmp   <= i_mul_rsp.res;
            ST_A_DN: r_dnext <= w_sat;
            ST_A_UR: r_uraw  <= w_sat;
            default: r_tmp   <= r_tmp;
        endcase
        if (w_load) begin
            r_out.drive   <= w_drive;
            r_out.clamped <= w_clamped;
        end
    end

`ifndef SYNTH
    a_start_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mul_req.start |-> !i_mul_rsp.busy)
        else $error("multiplier started while busy");

    a_accept_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (o_in_stall && (r_state == ST_M_BR)))
        else $error("sequencer did not start after an input transaction");

    a_no_clamp_without_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !i_cfg.mode_bits[0]) |=> (o_out_valid && !o_out.clamped))
        else $error("clamped flag set with limits disabled");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/pid_two_dof_controller_tb.sv
`timescale 1ns / 1ps

module pid_two_dof_controller_tb;
    import pid2_pkg::*;

    localparam int          Q_ONE       = 65536;
    localparam logic [31:0] W_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] W_MIN       = 32'h8000_0000;
    localparam longint      Q48_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      Q48_MIN     = -Q48_MAX - 1;
    localparam longint      Q32_MAX     = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      Q32_MIN     = -Q32_MAX - 1;
    localparam int          HOLD_CYCLES = 600;
    localparam int          PHASE_ITEMS = 150;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    t_in_item    in_item   = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = 3'd0;
    logic [31:0] cfg_data  = 32'd0;

    // Handshake flags captured at the rising edge, read by the falling-edge drivers
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    t_in_item  sample_queue[$];
    t_out_item drive_expected[$];
    t_out_item want;
    int        mismatch_count = 0;

    int   in_idle_max  = 10;
    int   out_idle_max = 10;
    int   in_gap       = 0;
    int   out_wait     = 0;
    logic out_armed    = 1'b0;
    logic hold_arm     = 1'b0;
    logic hold_taken   = 1'b0;

    // Shadow of the controller settings and state
    t_cfg   ctl_cfg;
    longint integ_acc      = 0;
    longint last_int_err   = 0;
    longint filt_acc       = 0;
    longint last_deriv_err = 0;

    pid_two_dof_controller u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic longint clip48(input longint v);
        if (v > Q48_MAX) return Q48_MAX;
        if (v < Q48_MIN) return Q48_MIN;
        return v;
    endfunction

    function automatic longint clip32(input longint v);
        if (v > Q32_MAX) return Q32_MAX;
        if (v < Q32_MIN) return Q32_MIN;
        return v;
    endfunction

    // Q16.16 product on magnitudes, truncated toward zero, saturated to 48 bits
    function automatic longint fx_mul(input longint a, input longint b);
        logic [127:0] ma;
        logic [127:0] mb;
        logic [127:0] prod;
        logic [127:0] lim;
        logic         neg;
        neg  = (a < 0) != (b < 0);
        ma   = (a < 0) ? 128'(-a) : 128'(a);
        mb   = (b < 0) ? 128'(-b) : 128'(b);
        prod = (ma * mb) >> 16;
        lim  = neg ? (128'(1) << 47) : ((128'(1) << 47) - 1);
        if (prod > lim) prod = lim;
        return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function automatic t_out_item pid_predict(input t_in_item s);
        longint    r, y, e_p, u_p, e_i, i_next, e_d, alpha, d_next, u_d, u_raw, u, lo, hi;
        logic      clamp;
        logic      freeze;
        t_out_item res;
        r      = $signed(s.reference);
        y      = $signed(s.measurement);
        lo     = $signed(ctl_cfg.limit_low);
        hi     = $signed(ctl_cfg.limit_high);
        e_p    = clip48(fx_mul($signed(ctl_cfg.weight_prop_ref), r) - y);
        u_p    = fx_mul($signed(ctl_cfg.gain_prop), e_p);
        e_i    = r - y;
        i_next = clip48(integ_acc + fx_mul(pid2_pkg::SAMPLE_PERIOD, last_int_err));
        e_d    = clip48(fx_mul($signed(ctl_cfg.weight_deriv_ref), r) - y);
        alpha  = clip48(longint'(Q_ONE)
                        - fx_mul(pid2_pkg::FILTER_COEFF, pid2_pkg::SAMPLE_PERIOD));
        d_next = clip48(fx_mul(alpha, filt_acc)
                        + fx_mul(pid2_pkg::FILTER_COEFF, clip48(e_d - last_deriv_err)));
        u_d    = fx_mul($signed(ctl_cfg.gain_deriv), d_next);
        u_raw  = clip48(u_p + fx_mul($signed(ctl_cfg.gain_int), i_next) + u_d);
        clamp  = 1'b0;
        if (ctl_cfg.mode_bits[0]) begin
            // Upper limit wins when the limits are crossed
            if (u_raw > hi) begin
                u     = hi;
                clamp = 1'b1;
            end else if (u_raw < lo) begin
                u     = lo;
                clamp = 1'b1;
            end else begin
                u = u_raw;
            end
        end else begin
            u = clip32(u_raw);
        end
        // Freeze the integrator only while the old error drives further into the limit
        freeze = ctl_cfg.mode_bits[1] && clamp &&
                 ((u_raw > hi && last_int_err > 0) || (u_raw < lo && last_int_err < 0));
        if (!freeze) integ_acc = i_next;
        filt_acc       = d_next;
        last_int_err   = e_i;
        last_deriv_err = e_d;
        res.drive   = 32'(u);
        res.clamped = clamp;
        return res;
    endfunction

    function automatic longint rand_span(input longint m);
        int unsigned span;
        span = 32'(2 * m);
        return longint'($urandom_range(0, span)) - m;
    endfunction

    function automatic logic [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return W_MIN;
            1: return W_MAX;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return 32'(Q_ONE);
        endcase
    endfunction

    function automatic logic [31:0] rand_gain();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return 32'(rand_span(4 * Q_ONE));
        if (sel < 8) return 32'(rand_span(Q_ONE / 8));
        if (sel < 9) return $urandom();
        return pick_edge();
    endfunction

    function automatic logic [31:0] rand_weight();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'(Q_ONE / 2);
            2: return 32'(Q_ONE);
            default: return rand_gain();
        endcase
    endfunction

    always @(posedge clk) begin : monitor
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (drive_expected.size() == 0) begin
                    $error("unexpected result: drive %0d clamped %0b",
                           $signed(out_item.drive), out_item.clamped);
                    mismatch_count++;
                end else begin
                    want = drive_expected.pop_front();
                    if (out_item.drive !== want.drive) begin
                        $error("drive mismatch: expected %0d, actual %0d",
                               $signed(want.drive), $signed(out_item.drive));
                        mismatch_count++;
                    end
                    if (out_item.clamped !== want.clamped) begin
                        $error("clamped mismatch: expected %0b, actual %0b",
                               want.clamped, out_item.clamped);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && !in_stall) drive_expected.push_back(pid_predict(in_item));
        end
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
    end

    always @(negedge clk) begin : sample_driver
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (in_fire) in_gap = $urandom_range(0, in_idle_max);
            if (in_gap > 0) begin
                in_gap--;
                in_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
                in_item  <= sample_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin : drive_receiver
        if (!hold_arm) hold_taken = 1'b0;
        if (out_fire) out_armed = 1'b0;
        // Draw a fresh wait for each result as it shows up; keep a long hold running
        if (out_valid === 1'b1 && !out_armed) begin
            out_armed = 1'b1;
            if (out_wait == 0) out_wait = $urandom_range(0, out_idle_max);
        end
        if (hold_arm && !hold_taken) begin
            hold_taken = 1'b1;
            out_wait   = HOLD_CYCLES;
        end
        if (out_wait > 0) begin
            out_wait--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic cfg_write(input t_cfg_idx idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_GAIN_PROP:        ctl_cfg.gain_prop        = data;
            CFG_GAIN_INT:         ctl_cfg.gain_int         = data;
            CFG_GAIN_DERIV:       ctl_cfg.gain_deriv       = data;
            CFG_WEIGHT_PROP_REF:  ctl_cfg.weight_prop_ref  = data;
            CFG_WEIGHT_DERIV_REF: ctl_cfg.weight_deriv_ref = data;
            CFG_LIMIT_LOW:        ctl_cfg.limit_low        = data;
            CFG_LIMIT_HIGH:       ctl_cfg.limit_high       = data;
            CFG_MODE_BITS:        ctl_cfg.mode_bits        = data[1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_controller(input logic [31:0] p, input logic [31:0] i,
                                  input logic [31:0] d, input logic [31:0] b,
                                  input logic [31:0] c, input logic [31:0] lo,
                                  input logic [31:0] hi, input logic [1:0] mode);
        cfg_write(CFG_GAIN_PROP, p);
        cfg_write(CFG_GAIN_INT, i);
        cfg_write(CFG_GAIN_DERIV, d);
        cfg_write(CFG_WEIGHT_PROP_REF, b);
        cfg_write(CFG_WEIGHT_DERIV_REF, c);
        cfg_write(CFG_LIMIT_LOW, lo);
        cfg_write(CFG_LIMIT_HIGH, hi);
        // Random upper bits must be ignored
        cfg_write(CFG_MODE_BITS, ($urandom() & 32'hFFFF_FFFC) | {30'b0, mode});
    endtask

    task automatic queue_sample(input logic [31:0] r, input logic [31:0] y);
        t_in_item s;
        s.reference   = r;
        s.measurement = y;
        sample_queue.push_back(s);
    endtask

    task automatic queue_random_samples(input int count);
        longint   amp, ref_lvl, meas_lvl;
        t_in_item s;
        int       sel;
        amp      = longint'(1) << $urandom_range(12, 29);
        ref_lvl  = 0;
        meas_lvl = 0;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                // Set-point steps with the measurement settling toward them
                if ($urandom_range(0, 9) == 0) ref_lvl = rand_span(amp);
                meas_lvl = meas_lvl + (ref_lvl - meas_lvl) / 8 + rand_span(amp / 64 + 1);
                s.reference   = 32'(clip32(ref_lvl));
                s.measurement = 32'(clip32(meas_lvl));
            end else if (sel < 85) begin
                s = {$urandom(), $urandom()};
            end else begin
                s.reference   = pick_edge();
                s.measurement = pick_edge();
            end
            sample_queue.push_back(s);
        end
    endtask

    task automatic random_phase();
        logic [31:0] lo_v, hi_v, tmp;
        longint      span;
        int          pick;
        span = longint'(1) << $urandom_range(16, 29);
        lo_v = 32'(rand_span(span));
        hi_v = 32'(rand_span(span));
        if ($signed(lo_v) > $signed(hi_v)) begin
            tmp  = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
        end
        pick = $urandom_range(0, 19);
        if (pick < 3) begin
            tmp  = lo_v;
            lo_v = hi_v;
            hi_v = tmp;
        end else if (pick < 5) begin
            lo_v = W_MIN;
            hi_v = W_MAX;
        end
        set_controller(rand_gain(), rand_gain(), rand_gain(), rand_weight(), rand_weight(),
                       lo_v, hi_v, 2'($urandom_range(0, 3)));
    endtask

    task automatic drain();
        do @(posedge clk);
        while (sample_queue.size() != 0 || in_valid || drive_expected.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    initial begin : sequencer
        ctl_cfg.gain_prop        = 32'd0;
        ctl_cfg.gain_int         = 32'd0;
        ctl_cfg.gain_deriv       = 32'd0;
        ctl_cfg.weight_prop_ref  = 32'(Q_ONE);
        ctl_cfg.weight_deriv_ref = 32'(Q_ONE);
        ctl_cfg.limit_low        = 32'd0;
        ctl_cfg.limit_high       = 32'd0;
        ctl_cfg.mode_bits        = 2'd2;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: zero gains give zero drive
        queue_sample(32'(Q_ONE), 32'd0);
        queue_sample(W_MAX, W_MIN);
        queue_sample(32'(-Q_ONE), 32'(2 * Q_ONE));
        drain();

        // Limits off, extreme weights: saturate the internal sums and the output
        set_controller(32'(Q_ONE), 32'(Q_ONE / 2), 32'(Q_ONE / 4), W_MAX, W_MIN,
                       32'd0, 32'd0, 2'd0);
        queue_sample(W_MAX, W_MIN);
        queue_sample(W_MIN, W_MAX);
        queue_sample(32'd0, 32'd0);
        queue_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_sample(W_MAX, W_MAX);
        queue_sample(W_MIN, W_MIN);
        queue_sample(32'd1, 32'hFFFF_FFFF);
        drain();

        // Limits and anti-windup on: clamp both ways, with and without freezing
        set_controller(32'(8 * Q_ONE), 32'(4 * Q_ONE), 32'd0, 32'(Q_ONE), 32'(Q_ONE),
                       32'(-10 * Q_ONE), 32'(10 * Q_ONE), 2'd3);
        queue_sample(32'(5 * Q_ONE), 32'd0);
        queue_sample(32'(5 * Q_ONE), 32'd0);
        queue_sample(32'(-5 * Q_ONE), 32'd0);
        queue_sample(32'(-5 * Q_ONE), 32'd0);
        queue_sample(32'd0, 32'(Q_ONE / 2));
        queue_sample(32'd0, 32'd0);
        drain();

        // Crossed limits: upper limit tested first
        set_controller(32'(Q_ONE), 32'd0, 32'd0, 32'(Q_ONE), 32'(Q_ONE),
                       32'(5 * Q_ONE), 32'(-5 * Q_ONE), 2'd1);
        queue_sample(32'(10 * Q_ONE), 32'd0);
        queue_sample(32'd0, 32'd0);
        queue_sample(32'(-10 * Q_ONE), 32'd0);
        queue_sample(32'(-3 * Q_ONE), 32'd0);
        drain();

        for (int k = 0; k < 12; k++) begin
            in_idle_max  = (k % 3 == 1) ? 0 : 10;
            out_idle_max = (k % 4 == 3) ? 0 : 10;
            if (k == 0) begin
                set_controller(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, 2'd3);
            end else if (k == 1) begin
                set_controller(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MAX, W_MIN, 2'd1);
            end else begin
                random_phase();
            end
            if (k == 2) begin
                // Hold off the output so the block backs up into its input
                in_idle_max = 0;
                hold_arm    = 1'b1;
            end
            queue_random_samples(PHASE_ITEMS);
            drain();
            hold_arm = 1'b0;
        end

        repeat (70) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #6400000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
